// ===== sv/dqav_pkg.sv =====
// Shared types and constants for the dotted-quad address validator.
// No dependencies; used by dqav_step and dotted_quad_address_validator_unit.
`default_nettype none

package dqav_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ValueW  = 9;
  localparam int unsigned LenW    = 2;
  localparam int unsigned CountW  = 3;

  localparam logic [CharW-1:0]  SepReset   = 8'd64;   // '@'
  localparam logic [CharW-1:0]  FmaxReset  = 8'd255;
  localparam logic [CharW-1:0]  CharZero   = 8'h30;   // '0'
  localparam logic [CharW-1:0]  CharNine   = 8'h39;   // '9'
  localparam logic [ValueW-1:0] ValueCap   = 9'd511;
  localparam logic [LenW-1:0]   LenCap     = 2'd3;
  localparam logic [CountW-1:0] CountCap   = 3'd7;
  localparam logic [CountW-1:0] SepsNeeded = 3'd3;
  localparam logic [CountW-1:0] FieldsNeeded = 3'd4;

  typedef enum logic [0:0] {
    CFG_SEPARATOR = 1'b0,
    CFG_FIELD_MAX = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ValueW-1:0] field_value;
    logic [LenW-1:0]   field_length;
    logic              leading_zero;
    logic [CountW-1:0] separators_seen;
    logic [CountW-1:0] fields_done;
    logic              word_error;
  } word_state_t;

endpackage

`default_nettype wire

// ===== sv/dotted_quad_address_validator_unit.sv =====
// Dotted-quad address validator: one character per request, verdict on last character.
// Path: a character is registered in the input register, processed combinationally by
// dqav_step, and its verdict is loaded into the output register on a word end.
// Throughput: one character per cycle; the input stage stalls only when a finished
// verdict is still held on a stalled output and the next word end is ready.
// Reset: async active low; clears parse state and handshakes, separator to '@', max 255.
`default_nettype none

module dotted_quad_address_validator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [dqav_pkg::CharW-1:0] cfg_data_i,
  // character request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dqav_pkg::CharW-1:0] ch_i,
  input  logic                       last_char_i,
  // verdict request channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       is_valid_o
);

  // Configuration registers.
  logic [dqav_pkg::CharW-1:0] sep_char_q;
  logic [dqav_pkg::CharW-1:0] field_max_q;

  // Input register: holds one character request.
  logic                       in_v_q;
  logic [dqav_pkg::CharW-1:0] ch_q;
  logic                       last_q;

  // Parse state carried across characters of a word.
  dqav_pkg::word_state_t      state_q, state_d;
  logic                       verdict_d;

  // Output register.
  logic                       out_v_q;
  logic                       is_valid_q;

  logic                       advance;
  logic                       out_free;

  // Output slot is free if empty or being taken this cycle.
  assign out_free   = !out_v_q || !out_stall_i;
  // Only a word end needs the output slot; other characters always move on.
  assign advance    = in_v_q && (!last_q || out_free);
  assign in_stall_o = in_v_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_char_q  <= dqav_pkg::SepReset;
      field_max_q <= dqav_pkg::FmaxReset;
    end else if (cfg_we_i) begin
      case (dqav_pkg::cfg_idx_e'(cfg_idx_i))
        dqav_pkg::CFG_SEPARATOR: sep_char_q  <= cfg_data_i;
        dqav_pkg::CFG_FIELD_MAX: field_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dqav_step u_step (
    .state_i     (state_q),
    .ch_i        (ch_q),
    .last_char_i (last_q),
    .sep_char_i  (sep_char_q),
    .field_max_i (field_max_q),
    .state_o     (state_d),
    .is_valid_o  (verdict_d)
  );

  // Input stage: load a new request whenever the register is empty or the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_char_i;
    end
  end

  // Advance the parse state once per processed character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output stage: load a verdict on a word end, drop it when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance && last_q) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      is_valid_q <= verdict_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign is_valid_o  = is_valid_q;

endmodule

`default_nettype wire

// ===== sv/dqav_step.sv =====
// Per-character update of the word parse state and the end-of-word verdict.
// Depends on dqav_pkg (state struct and character constants).
`default_nettype none

module dqav_step (
  input  dqav_pkg::word_state_t        state_i,
  input  logic [dqav_pkg::CharW-1:0]   ch_i,
  input  logic                         last_char_i,
  input  logic [dqav_pkg::CharW-1:0]   sep_char_i,
  input  logic [dqav_pkg::CharW-1:0]   field_max_i,
  output dqav_pkg::word_state_t        state_o,
  output logic                         is_valid_o
);

  logic                          is_digit;
  logic [3:0]                    digit;
  logic [12:0]                   value_next;
  dqav_pkg::word_state_t         s;

  // Close the current field: check it, count it, clear it.
  function automatic dqav_pkg::word_state_t close_field(dqav_pkg::word_state_t st,
                                                        logic [dqav_pkg::CharW-1:0] fmax);
    dqav_pkg::word_state_t r;
    r = st;
    if (st.field_length == '0) begin
      r.word_error = 1'b1;
    end else if (st.leading_zero && st.field_length > 2'd1) begin
      r.word_error = 1'b1;
    end else if (st.field_value > {1'b0, fmax}) begin
      r.word_error = 1'b1;
    end else if (st.fields_done < dqav_pkg::CountCap) begin
      r.fields_done = st.fields_done + 3'd1;
    end
    r.field_value  = '0;
    r.field_length = '0;
    r.leading_zero = 1'b0;
    return r;
  endfunction

  assign is_digit   = (ch_i >= dqav_pkg::CharZero) && (ch_i <= dqav_pkg::CharNine);
  // The low nibble of '0'..'9' is the digit value.
  assign digit      = ch_i[3:0];
  assign value_next = {1'b0, state_i.field_value, 3'b000}
                    + {3'b000, state_i.field_value, 1'b0}
                    + {9'd0, digit};

  always_comb begin
    s          = state_i;
    is_valid_o = 1'b0;
    if (!s.word_error) begin
      if (ch_i == sep_char_i) begin
        if (s.separators_seen < dqav_pkg::CountCap) begin
          s.separators_seen = s.separators_seen + 3'd1;
        end
        s = close_field(s, field_max_i);
      end else if (is_digit) begin
        if (s.field_length == '0 && ch_i == dqav_pkg::CharZero) begin
          s.leading_zero = 1'b1;
        end
        if (s.field_length < dqav_pkg::LenCap) begin
          s.field_length = s.field_length + 2'd1;
        end
        s.field_value = (value_next > {4'd0, dqav_pkg::ValueCap}) ?
                        dqav_pkg::ValueCap : value_next[dqav_pkg::ValueW-1:0];
      end else begin
        s.word_error = 1'b1;
      end
      if (s.separators_seen > dqav_pkg::SepsNeeded ||
          s.fields_done > dqav_pkg::FieldsNeeded) begin
        s.word_error = 1'b1;
      end
    end
    if (last_char_i) begin
      if (!s.word_error) begin
        s = close_field(s, field_max_i);
        if (s.fields_done > dqav_pkg::FieldsNeeded) begin
          s.word_error = 1'b1;
        end
      end
      is_valid_o = !s.word_error && s.separators_seen == dqav_pkg::SepsNeeded &&
                   s.fields_done == dqav_pkg::FieldsNeeded;
      s = '0;
    end
  end

  assign state_o = s;

endmodule

`default_nettype wire
